FILE: hdl/p2c_pkg.sv
// ----------------------------------------------------------------------------
// p2c_pkg
// Shared constants and types of the planar to chunky converter.
// ----------------------------------------------------------------------------
package p2c_pkg;

  // widest image row the line store holds
  localparam int unsigned MAX_WIDTH = 1024;

  // one line store row holds the eight pixels of one plane byte
  localparam int unsigned PIX_PER_BYTE = 8;
  localparam int unsigned LS_DEPTH     = MAX_WIDTH / PIX_PER_BYTE;
  localparam int unsigned LS_AW        = (LS_DEPTH > 1) ? $clog2(LS_DEPTH) : 1;
  localparam int unsigned ROW_W        = 8 * PIX_PER_BYTE;

  // pixel position arithmetic, wide enough for the row width register and MAX_WIDTH
  localparam int unsigned XW = 13;

  // configuration register widths
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PLANE_COUNT   = 2'd0,
    REG_ROW_WIDTH     = 2'd1,
    REG_BYTES_PER_ROW = 2'd2,
    REG_IMAGE_HEIGHT  = 2'd3
  } cfg_reg_e;

  // finished pixels of one last-plane byte, leftmost pixel in the top byte
  typedef struct packed {
    logic [ROW_W-1:0] pixels;
    logic [3:0]       count;
    logic             row_end;
    logic             image_end;
  } burst_t;

endpackage

FILE: hdl/p2c_if.sv
// ----------------------------------------------------------------------------
// p2c_in_if / p2c_out_if
// Valid/ready channels of the planar to chunky converter.
// ----------------------------------------------------------------------------
interface p2c_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] plane_byte;

  modport source (output valid, output plane_byte, input ready);
  modport sink   (input valid, input plane_byte, output ready);
endinterface

interface p2c_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;
  logic       row_end;
  logic       image_end;
  logic       burst_end;

  modport source (output valid, output pixel, output row_end, output image_end,
                  output burst_end, input ready);
  modport sink   (input valid, input pixel, input row_end, input image_end,
                  input burst_end, output ready);
endinterface

FILE: hdl/planar_to_chunky_converter.sv
// ----------------------------------------------------------------------------
// planar_to_chunky_converter
// Turns bit-plane rows into chunky pixels through a read-modify-write line store.
// ----------------------------------------------------------------------------
// Takes one plane byte per cycle unless stage 1 holds a burst that waits for
// the serializer. Bytes of planes before the last, and padding bytes, produce
// nothing and never stall. A byte of the last plane produces up to eight pixels,
// which leave one per cycle while the output is ready, through the output
// serializer; the next byte is taken while the current burst drains. The first
// pixel is offered once its byte has passed stage 1 and been loaded into the
// serializer. The line store is one memory of MAX_WIDTH/8 rows of eight pixels
// with a single read port and a single write port; back-to-back accesses to the
// same row are forwarded. The store needs no initialization after reset.
module planar_to_chunky_converter
  import p2c_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  p2c_in_if.sink                in_i,
  p2c_out_if.source             out_o
);

  // configuration
  logic [3:0]  plane_count_q;
  logic [10:0] row_width_q;
  logic [7:0]  bpr_q;
  logic [15:0] height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_count_q <= 4'd8;
      row_width_q   <= 11'd320;
      bpr_q         <= 8'd40;
      height_q      <= 16'd200;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_PLANE_COUNT:   plane_count_q <= cfg_data_i[3:0];
        REG_ROW_WIDTH:     row_width_q   <= cfg_data_i[10:0];
        REG_BYTES_PER_ROW: bpr_q         <= cfg_data_i[7:0];
        REG_IMAGE_HEIGHT:  height_q      <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // effective limits
  logic [3:0]    cnt_eff;
  logic [7:0]    bpr_eff;
  logic [15:0]   h_eff;
  logic [XW-1:0] w_eff, w_tmp, bpr8;

  always_comb begin
    cnt_eff = plane_count_q;
    if (plane_count_q == 4'd0) cnt_eff = 4'd1;
    if (plane_count_q > 4'd8)  cnt_eff = 4'd8;
    bpr_eff = (bpr_q == 8'd0) ? 8'd1 : bpr_q;
    h_eff   = (height_q == 16'd0) ? 16'd1 : height_q;
    bpr8    = XW'({bpr_eff, 3'b000});
    w_tmp   = (row_width_q == 11'd0) ? XW'(1) : XW'(row_width_q);
    if (w_tmp > XW'(MAX_WIDTH)) w_tmp = XW'(MAX_WIDTH);
    w_eff   = (w_tmp > bpr8) ? bpr8 : w_tmp;
  end

  // position counters, saturated against the current limits
  logic [2:0]  plane_q, plane_eff;
  logic [7:0]  byte_q, byte_eff;
  logic [15:0] row_q, row_eff;
  logic        last_plane, last_byte, last_row;

  assign plane_eff  = ({1'b0, plane_q} >= cnt_eff) ? 3'(cnt_eff - 4'd1) : plane_q;
  assign byte_eff   = (byte_q >= bpr_eff) ? (bpr_eff - 8'd1) : byte_q;
  assign row_eff    = (row_q >= h_eff) ? (h_eff - 16'd1) : row_q;
  assign last_plane = ({1'b0, plane_eff} == (cnt_eff - 4'd1));
  assign last_byte  = (byte_eff == (bpr_eff - 8'd1));
  assign last_row   = (row_eff == (h_eff - 16'd1));

  // pixels covered by this byte
  logic [XW-1:0] x0, diff;
  logic          in_row;
  logic [3:0]    k;

  assign x0     = XW'({byte_eff, 3'b000});
  assign in_row = (x0 < w_eff);
  assign diff   = w_eff - x0;
  assign k      = !in_row ? 4'd0 : ((diff > XW'(8)) ? 4'd8 : diff[3:0]);

  // stage 1: line store row is read on accept, modified and written here
  logic             s1_valid_q;
  logic [7:0]       s1_byte_q;
  logic [2:0]       s1_plane_q;
  logic             s1_wr_q, s1_last_q, s1_rend_q, s1_img_q;
  logic [3:0]       s1_k_q;
  logic [LS_AW-1:0] s1_addr_q;
  logic             s1_adv;
  logic             in_acc;
  logic             ser_free;
  logic             ser_load;
  burst_t           burst;

  assign ser_load   = s1_valid_q && s1_last_q && s1_wr_q;
  assign s1_adv     = s1_valid_q && (!ser_load || ser_free);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_acc     = in_i.valid && in_i.ready;

  // line store
  logic [ROW_W-1:0] ls_mem [LS_DEPTH];
  logic [ROW_W-1:0] rd_q, fwd_data_q, old_row, new_row;
  logic             fwd_q;
  logic             ls_we;
  logic [LS_AW-1:0] raddr;

  assign raddr = LS_AW'(byte_eff);
  assign ls_we = s1_adv && s1_wr_q;

  always_ff @(posedge clk_i) begin
    if (ls_we) begin
      ls_mem[s1_addr_q] <= new_row;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_q       <= ls_mem[raddr];
      fwd_data_q <= new_row;
    end
  end

  // write in the same cycle as the read to the same row: take the new data
  assign old_row = fwd_q ? fwd_data_q : rd_q;

  always_comb begin
    new_row = '0;
    for (int i = 0; i < PIX_PER_BYTE; i++) begin
      logic [7:0] px;
      px = (s1_plane_q == 3'd0) ? 8'h00 : old_row[ROW_W-1-8*i -: 8];
      px[s1_plane_q] = px[s1_plane_q] | s1_byte_q[7-i];
      new_row[ROW_W-1-8*i -: 8] = px;
    end
  end

  assign burst.pixels    = new_row;
  assign burst.count     = s1_k_q;
  assign burst.row_end   = s1_rend_q;
  assign burst.image_end = s1_rend_q && s1_img_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
      plane_q    <= 3'd0;
      byte_q     <= 8'd0;
      row_q      <= 16'd0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
        fwd_q      <= ls_we && (s1_addr_q == raddr);
        if (!last_byte) begin
          byte_q  <= byte_eff + 8'd1;
          plane_q <= plane_eff;
          row_q   <= row_eff;
        end else begin
          byte_q <= 8'd0;
          if (!last_plane) begin
            plane_q <= plane_eff + 3'd1;
            row_q   <= row_eff;
          end else begin
            plane_q <= 3'd0;
            row_q   <= last_row ? 16'd0 : (row_eff + 16'd1);
          end
        end
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_byte_q  <= in_i.plane_byte;
      s1_plane_q <= plane_eff;
      s1_wr_q    <= in_row;
      s1_last_q  <= last_plane;
      s1_k_q     <= k;
      s1_rend_q  <= (diff <= XW'(8));
      s1_img_q   <= last_row;
      s1_addr_q  <= raddr;
    end
  end

  p2c_serializer u_ser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (ser_load && s1_adv),
    .burst_i (burst),
    .free_o  (ser_free),
    .out_o   (out_o)
  );

`ifndef SYNTHESIS
  // stage 1 holds only while a burst waits for the serializer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |-> (ser_load && !ser_free))
    else $error("stage 1 stalled without a waiting burst");

  // a loaded burst is offered on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ser_load && s1_adv && (s1_k_q != 4'd0)) |=> out_o.valid)
    else $error("loaded burst not presented");

  // the plane counter stays inside the plane count after each item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !cfg_we_i) |=> ({1'b0, plane_q} < cnt_eff))
    else $error("plane counter beyond plane count");
`endif

endmodule

FILE: hdl/p2c_serializer.sv
// ----------------------------------------------------------------------------
// p2c_serializer
// Holds a burst of finished pixels; one leaves per cycle while out_o.ready.
// ----------------------------------------------------------------------------
module p2c_serializer
  import p2c_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     load_i,
  input  burst_t   burst_i,
  output logic     free_o,
  p2c_out_if.source out_o
);

  logic [ROW_W-1:0] data_q, data_d;
  logic [3:0]       cnt_q, cnt_d;
  logic             row_end_q, row_end_d;
  logic             img_end_q, img_end_d;
  logic             last_px;
  logic             emit;

  assign emit    = out_o.valid && out_o.ready;
  assign last_px = (cnt_q == 4'd1);
  assign free_o  = (cnt_q == 4'd0) || (last_px && out_o.ready);

  assign out_o.valid     = (cnt_q != 4'd0);
  assign out_o.pixel     = data_q[ROW_W-1 -: 8];
  assign out_o.burst_end = last_px;
  assign out_o.row_end   = last_px && row_end_q;
  assign out_o.image_end = last_px && img_end_q;

  always_comb begin
    data_d    = data_q;
    cnt_d     = cnt_q;
    row_end_d = row_end_q;
    img_end_d = img_end_q;
    priority if (load_i && free_o) begin
      data_d    = burst_i.pixels;
      cnt_d     = burst_i.count;
      row_end_d = burst_i.row_end;
      img_end_d = burst_i.image_end;
    end else if (emit) begin
      data_d = {data_q[ROW_W-9:0], 8'h00};
      cnt_d  = cnt_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 4'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q    <= data_d;
    row_end_q <= row_end_d;
    img_end_q <= img_end_d;
  end

endmodule
